/* rtl/core/ptq_pkg.sv */
// ----------------------------------------------------------------------------
// Periodic timer queue package
// Shared types and constants for the sorted periodic timer queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

    localparam int unsigned TimerSlotsDefault = 16;
    localparam int unsigned MaxResults = 16;

    typedef enum logic [1:0] {
        ACT_ADD      = 2'd0,
        ACT_DEL      = 2'd1,
        ACT_DEL_CLI  = 2'd2,
        ACT_TICK     = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  client_id;
        logic [15:0] event_id;
        logic [15:0] interval;
    } t_in_item;

    typedef struct packed {
        logic        fired;
        logic [7:0]  fired_client;
        logic [15:0] fired_event;
        logic        status;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        valid;
        logic [31:0] due;
        logic [15:0] period;
        logic [7:0]  client;
        logic [15:0] event_id;
    } t_entry;

    // Command broadcast to every cell of the row.
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SCRUB  = 2'd2,
        CMD_POP    = 2'd3
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd   cmd;
        t_entry      ins;
        logic [7:0]  client;
        logic [15:0] event_id;
        logic        match_all;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCRUB,
        ST_CHECK,
        ST_FIRE,
        ST_OUT
    } t_state;

    function automatic logic not_before(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return ~d[31];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/ptq_cell.sv */
// ----------------------------------------------------------------------------
// Periodic timer queue cell
// One slot of the sorted row; takes from its left or right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_cell
    import ptq_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_entry i_left,
    input  wire t_entry i_right,
    input  wire         i_left_kill,
    output t_entry      o_entry,
    output logic        o_kill
);

    t_entry r_e;
    t_entry n_e;
    logic   w_ins_here;
    logic   w_left_before;

    // Insert goes after every entry whose due is not after the new one.
    assign w_left_before = i_left.valid && not_before(i_ctl.ins.due, i_left.due);
    assign w_ins_here = !(r_e.valid && not_before(i_ctl.ins.due, r_e.due));
    assign o_kill = r_e.valid && (r_e.client == i_ctl.client)
                    && (i_ctl.match_all || (r_e.event_id == i_ctl.event_id));
    assign o_entry = r_e;

    always_comb begin
        n_e = r_e;
        case (i_ctl.cmd)
            CMD_INSERT: begin
                if (w_ins_here) begin
                    if (w_left_before) begin
                        n_e = i_ctl.ins;
                    end else begin
                        n_e = i_left;
                    end
                end
            end
            CMD_SCRUB: begin
                if (i_left_kill || o_kill) begin
                    n_e = i_right;
                end
            end
            CMD_POP: begin
                n_e = i_right;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e <= '0;
        end else begin
            r_e <= n_e;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/periodic_timer_queue.sv */
// Sequence per input item: an add goes straight to the result; a delete scrubs the
// row until no slot matches; a tick pops and reinserts each fired timer in turn.
// One item at a time: the next is accepted only once the block is idle and its last
// result has been taken.
// The row of cells inserts or removes one entry per cycle.
// Reset (synchronous, active low) clears the tick counter and all slots.
// ----------------------------------------------------------------------------
// Periodic timer queue
// Row of slot cells kept sorted by due time, with a small sequencer on top.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_queue
    import ptq_pkg::*;
#(
    parameter int unsigned TIMER_SLOTS = TimerSlotsDefault
)(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_ready,
    input  wire t_in_item i_item,
    output logic      o_valid,
    input  wire       i_ready,
    output t_out_item o_item
);

    localparam int unsigned CntW = $clog2(MaxResults + 1);

    t_state     r_state, n_state;
    t_in_item   r_cmd, n_cmd;
    logic [31:0] r_now, n_now;
    logic [CntW-1:0] r_cnt, n_cnt;
    t_out_item  r_out, n_out;
    logic       r_ov, n_ov;
    t_cell_ctl  w_ctl;
    t_entry     w_ent [TIMER_SLOTS];
    t_entry     w_left [TIMER_SLOTS];
    t_entry     w_right [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] w_kill;
    logic [TIMER_SLOTS-1:0] w_lkill;
    logic [15:0] w_per;

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_row
        if (g == 0) begin : g_l0
            assign w_left[g]  = w_ctl.ins;
            assign w_lkill[g] = 1'b0;
        end else begin : g_ln
            assign w_left[g]  = w_ent[g-1];
            assign w_lkill[g] = w_lkill[g-1] | w_kill[g-1];
        end
        if (g == TIMER_SLOTS - 1) begin : g_rl
            assign w_right[g] = '0;
        end else begin : g_rn
            assign w_right[g] = w_ent[g+1];
        end
        ptq_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_left     (w_left[g]),
            .i_right    (w_right[g]),
            .i_left_kill(w_lkill[g]),
            .o_entry    (w_ent[g]),
            .o_kill     (w_kill[g])
        );
    end

    assign o_ready = (r_state == ST_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_now   <= '0;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_now   <= n_now;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
        end
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_now   = r_now;
        n_cnt   = r_cnt;
        n_out   = r_out;
        n_ov    = r_ov && !i_ready;
        w_ctl   = '0;
        w_ctl.client    = r_cmd.client_id;
        w_ctl.event_id  = r_cmd.event_id;
        w_ctl.match_all = (r_cmd.action == ACT_DEL_CLI);
        w_per = (r_cmd.interval == '0) ? 16'd1 : r_cmd.interval;
        w_ctl.ins.valid    = 1'b1;
        w_ctl.ins.due      = r_now + {16'd0, w_per};
        w_ctl.ins.period   = w_per;
        w_ctl.ins.client   = r_cmd.client_id;
        w_ctl.ins.event_id = r_cmd.event_id;
        case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    n_cmd = i_item;
                    n_cnt = '0;
                    case (t_action'(i_item.action))
                        ACT_ADD:  n_state = ST_OUT;
                        ACT_TICK: begin
                            n_now   = r_now + 32'd1;
                            n_state = ST_CHECK;
                        end
                        default:  n_state = ST_SCRUB;
                    endcase
                end
            end
            ST_SCRUB: begin
                w_ctl.cmd = CMD_SCRUB;
                if (w_kill == '0) begin
                    n_state = ST_OUT;
                end
            end
            ST_CHECK: begin
                if (!r_ov || i_ready) begin
                    if (r_cnt < CntW'(MaxResults) && w_ent[0].valid
                        && not_before(r_now, w_ent[0].due)) begin
                        if (r_cnt != '0) begin
                            n_out = '{fired: 1'b1, fired_client: r_cmd.client_id,
                                      fired_event: r_cmd.event_id, status: 1'b0,
                                      last: 1'b0};
                            n_ov = 1'b1;
                        end
                        w_ctl.cmd = CMD_POP;
                        n_cmd.client_id = w_ent[0].client;
                        n_cmd.event_id  = w_ent[0].event_id;
                        n_cmd.interval  = w_ent[0].period;
                        n_state = ST_FIRE;
                    end else if (r_cnt == '0) begin
                        n_out = '{fired: 1'b0, fired_client: '0, fired_event: '0,
                                  status: 1'b0, last: 1'b1};
                        n_ov = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_out = '{fired: 1'b1, fired_client: r_cmd.client_id,
                                  fired_event: r_cmd.event_id, status: 1'b0, last: 1'b1};
                        n_ov = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FIRE: begin
                w_ctl.cmd = CMD_INSERT;
                n_cnt = r_cnt + CntW'(1);
                n_state = ST_CHECK;
            end
            ST_OUT: begin
                if (!r_ov) begin
                    if (r_cmd.action == ACT_ADD) begin
                        if (w_ent[TIMER_SLOTS-1].valid) begin
                            n_out = '{fired: 1'b0, fired_client: '0, fired_event: '0,
                                      status: 1'b1, last: 1'b1};
                        end else begin
                            w_ctl.cmd = CMD_INSERT;
                            n_out = '{fired: 1'b0, fired_client: '0, fired_event: '0,
                                      status: 1'b0, last: 1'b1};
                        end
                    end else begin
                        n_out = '{fired: 1'b0, fired_client: '0, fired_event: '0,
                                  status: 1'b0, last: 1'b1};
                    end
                    n_ov = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* tb/periodic_timer_queue_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Periodic timer queue testbench
// Drives add, delete, delete-client and tick items through the block with
// random idling on both sides, keeps its own sorted timer list to work out
// the expected expiries, and checks every result item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_timer_queue_test;
    import ptq_pkg::*;

    localparam int unsigned Slots = 16;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;

    periodic_timer_queue #(.TIMER_SLOTS(Slots)) i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item)
    );

    typedef struct {
        logic [31:0] due;
        logic [15:0] period;
        logic [7:0]  client;
        logic [15:0] event_id;
    } t_timer;

    typedef struct {
        t_in_item  item;
        logic      known;
        t_out_item result;
    } t_row;

    logic [31:0] tick_count;
    t_timer      timer_list[$];
    t_out_item   pending_results[$];
    int          errors;
    bit          hold_off;
    bit          no_idle;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #4000000;
        $display("[periodic_timer_queue] ERROR");
        $finish;
    end

    function automatic bit due_not_before(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return ~d[31];
    endfunction

    function automatic void place_timer(t_timer t);
        int pos;
        pos = timer_list.size();
        while (pos > 0 && !due_not_before(t.due, timer_list[pos - 1].due)) begin
            pos--;
        end
        timer_list.insert(pos, t);
    endfunction

    function automatic t_out_item make_result(logic f, logic [7:0] c, logic [15:0] e,
                                              logic s, logic l);
        t_out_item r;
        r.fired = f;
        r.fired_client = c;
        r.fired_event = e;
        r.status = s;
        r.last = l;
        return r;
    endfunction

    function automatic void predict_timers(t_in_item it);
        t_timer t;
        logic [15:0] p;
        int i;
        int k;
        case (t_action'(it.action))
            ACT_ADD: begin
                p = (it.interval == 16'd0) ? 16'd1 : it.interval;
                if (timer_list.size() >= Slots) begin
                    pending_results.insert(pending_results.size(), make_result(0, 0, 0, 1, 1));
                end else begin
                    t.due = tick_count + 32'(p);
                    t.period = p;
                    t.client = it.client_id;
                    t.event_id = it.event_id;
                    place_timer(t);
                    pending_results.insert(pending_results.size(), make_result(0, 0, 0, 0, 1));
                end
            end
            ACT_DEL, ACT_DEL_CLI: begin
                i = 0;
                while (i < timer_list.size()) begin
                    if (timer_list[i].client == it.client_id &&
                        (it.action == ACT_DEL_CLI || timer_list[i].event_id == it.event_id)) begin
                        timer_list.delete(i);
                    end else begin
                        i++;
                    end
                end
                pending_results.insert(pending_results.size(), make_result(0, 0, 0, 0, 1));
            end
            default: begin
                tick_count = tick_count + 32'd1;
                k = 0;
                while (k < MaxResults && timer_list.size() > 0 &&
                       due_not_before(tick_count, timer_list[0].due)) begin
                    t = timer_list[0];
                    timer_list.delete(0);
                    pending_results.insert(pending_results.size(),
                                           make_result(1, t.client, t.event_id, 0, 0));
                    t.due = tick_count + 32'(t.period);
                    place_timer(t);
                    k++;
                end
                if (k == 0) begin
                    pending_results.insert(pending_results.size(), make_result(0, 0, 0, 0, 1));
                end else begin
                    pending_results[pending_results.size() - 1].last = 1'b1;
                end
            end
        endcase
    endfunction

    function automatic t_in_item make_item(logic [1:0] a, logic [7:0] c, logic [15:0] e,
                                           logic [15:0] iv);
        t_in_item it;
        it.action = a;
        it.client_id = c;
        it.event_id = e;
        it.interval = iv;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        while (!no_idle && $urandom_range(99) < 26) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        predict_timers(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic send_random(int count);
        logic [1:0] a;
        logic [7:0] c;
        int r;
        repeat (count) begin
            r = $urandom_range(99);
            a = (r < 40) ? ACT_ADD : (r < 55) ? ACT_DEL : (r < 62) ? ACT_DEL_CLI : ACT_TICK;
            c = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            send_item(make_item(a, c,
                ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(3)),
                ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4))));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result item %p", out_item);
                    errors++;
                end else begin
                    t_out_item want;
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (out_item.fired !== want.fired) begin
                        $error("fired: expected %0h actual %0h", want.fired, out_item.fired);
                        errors++;
                    end
                    if (out_item.fired_client !== want.fired_client) begin
                        $error("fired_client: expected %0h actual %0h",
                               want.fired_client, out_item.fired_client);
                        errors++;
                    end
                    if (out_item.fired_event !== want.fired_event) begin
                        $error("fired_event: expected %0h actual %0h",
                               want.fired_event, out_item.fired_event);
                        errors++;
                    end
                    if (out_item.status !== want.status) begin
                        $error("status: expected %0h actual %0h", want.status, out_item.status);
                        errors++;
                    end
                    if (out_item.last !== want.last) begin
                        $error("last: expected %0h actual %0h", want.last, out_item.last);
                        errors++;
                    end
                end
            end
        end
        out_ready <= !hold_off && (no_idle || $urandom_range(99) >= 26);
    end

    initial begin
        t_row rows[$];
        t_row row;
        int n;
        errors = 0;
        tick_count = 0;
        hold_off = 1'b0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Tick on an empty table, deletes with no match, zero and largest intervals.
        row.known = 1'b1;
        row.item = make_item(ACT_TICK, 8'hFF, 16'hFFFF, 16'hFFFF);
        row.result = make_result(0, 0, 0, 0, 1);
        rows.insert(rows.size(), row);
        row.item = make_item(ACT_DEL, 8'h00, 16'h0000, 16'h0000);
        rows.insert(rows.size(), row);
        row.item = make_item(ACT_DEL_CLI, 8'hFF, 16'h0000, 16'h0000);
        rows.insert(rows.size(), row);
        row.item = make_item(ACT_ADD, 8'hAA, 16'h5555, 16'h0000);
        rows.insert(rows.size(), row);
        row.item = make_item(ACT_ADD, 8'hFF, 16'hFFFF, 16'hFFFF);
        rows.insert(rows.size(), row);
        row.item = make_item(ACT_TICK, 8'h00, 16'h0000, 16'h0000);
        row.result = make_result(1, 8'hAA, 16'h5555, 0, 1);
        rows.insert(rows.size(), row);
        row.known = 1'b0;
        // Fill the table, then one more add reports full.
        for (int i = 0; i < 14; i++) begin
            row.item = make_item(ACT_ADD, 8'(i % 3), 16'(i), 16'(i % 2 + 1));
            rows.insert(rows.size(), row);
        end
        row.known = 1'b1;
        row.item = make_item(ACT_ADD, 8'h55, 16'hAAAA, 16'h0001);
        row.result = make_result(0, 0, 0, 1, 1);
        rows.insert(rows.size(), row);
        row.known = 1'b0;
        // Many timers due at once, then removals by event and by client.
        row.item = make_item(ACT_TICK, 8'h00, 16'h0000, 16'h0000);
        rows.insert(rows.size(), row);
        rows.insert(rows.size(), row);
        row.item = make_item(ACT_DEL, 8'h01, 16'h0001, 16'h0000);
        rows.insert(rows.size(), row);
        row.item = make_item(ACT_DEL_CLI, 8'h00, 16'h0000, 16'h0000);
        rows.insert(rows.size(), row);

        foreach (rows[i]) begin
            send_item(rows[i].item);
            n = pending_results.size() - 1;
            if (rows[i].known && pending_results[n] != rows[i].result) begin
                $error("directed row %0d: expected %p predicted %p",
                       i, rows[i].result, pending_results[n]);
                errors++;
            end
        end

        // Receiver holds off while the sender keeps offering items.
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            send_random(12);
        join
        wait_drained();

        no_idle = 1'b1;
        send_random(40);
        no_idle = 1'b0;
        send_random(53);
        wait_drained();

        if (errors == 0) begin
            $display("[periodic_timer_queue] OK");
        end else begin
            $display("[periodic_timer_queue] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
